[rtl/md5_pkg.sv]
package md5_pkg;

   // Initial chaining values, word A first.
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hEFCDAB89;
   localparam logic [31:0] IV_C = 32'h98BADCFE;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [7:0] ZERO_BYTE   = 8'h00;
   localparam logic [5:0] LAST_POS    = 6'd63;
   localparam logic [5:0] PAD_END_POS = 6'd55;
   localparam logic [5:0] LEN_POS     = 6'd56;
   localparam logic [5:0] LAST_ROUND  = 6'd63;

   localparam logic [31:0] ROUND_K [64] = '{
      32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
      32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
      32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
      32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
      32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
      32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
      32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
      32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
      32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
      32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
      32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
      32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
      32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
      32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
      32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
      32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
   };

   // Rotation amounts indexed by {round group, round[1:0]}.
   localparam logic [4:0] ROT_AMT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef logic [3:0][31:0] md5_words_type;

   typedef struct packed {
      logic       en;
      logic [5:0] addr;
      logic [7:0] data;
   } md5_buf_wr_type;

   typedef struct packed {
      logic start;
      logic reinit;
   } md5_cmp_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABS_WAIT,
      ST_PAD,
      ST_PAD_WAIT,
      ST_LEN,
      ST_FIN_WAIT,
      ST_FIN_LOAD
   } md5_state_type;

   // Message word used by a given round.
   function automatic logic [3:0] msg_index(input logic [5:0] round);
      logic [3:0] i4;
      logic [3:0] g;
      i4 = round[3:0];
      case (round[5:4])
         2'd0: g = i4;
         2'd1: g = i4 + {i4[1:0], 2'b00} + 4'd1;
         2'd2: g = i4 + {i4[2:0], 1'b0} + 4'd5;
         2'd3: g = {i4[0], 3'b000} - i4;
         default: g = i4;
      endcase
      return g;
   endfunction

   function automatic logic [31:0] round_fn(input logic [1:0] group, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      case (group)
         2'd0: f = d ^ (b & (c ^ d));
         2'd1: f = c ^ (d & (b ^ c));
         2'd2: f = b ^ c ^ d;
         2'd3: f = c ^ (b | ~d);
         default: f = b ^ c ^ d;
      endcase
      return f;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] t;
      t = {x, x} << s;
      return t[63:32];
   endfunction

endpackage

[rtl/md5_if.sv]
interface md5_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [1:0]  word_index;
   logic        last;

   modport source (output valid, output digest_word, output word_index, output last,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last,
                 output ready);
endinterface

[rtl/md5_block_buf.sv]
module md5_block_buf (
   input  logic                    clock,
   input  md5_pkg::md5_buf_wr_type wr,
   input  logic [3:0]              rd_addr,
   output logic [31:0]             rd_data
);
   import md5_pkg::*;

   // Sixteen little-endian message words with a byte-wide write port.
   logic [31:0] mem_ff [16];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr[5:2]][{wr.addr[1:0], 3'b000} +: 8] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/md5_compress.sv]
module md5_compress (
   input  logic                     clock,
   input  logic                     reset,
   input  md5_pkg::md5_cmp_ctl_type ctl,
   input  logic [31:0]              rd_data,
   output logic [3:0]               rd_addr,
   output md5_pkg::md5_words_type   chain,
   output logic                     done
);
   import md5_pkg::*;

   logic [31:0]   a_ff, b_ff, c_ff, d_ff;
   md5_words_type chain_ff;
   logic [5:0]    round_ff;
   logic          run_ff;
   logic          fin_ff;

   logic [1:0]    group;
   logic [31:0]   sum;
   logic [31:0]   new_b;

   // The word for round 0 is fetched on the start edge; the byte written in
   // that cycle always lands in the last word, so no forwarding is needed.
   assign rd_addr = run_ff ? msg_index(6'(round_ff + 6'd1)) : msg_index(6'd0);

   assign group = round_ff[5:4];
   assign sum   = a_ff + round_fn(group, b_ff, c_ff, d_ff) + rd_data + ROUND_K[round_ff];
   assign new_b = b_ff + rotl32(sum, ROT_AMT[{group, round_ff[1:0]}]);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         fin_ff   <= 1'b0;
         round_ff <= '0;
         chain_ff <= {IV_D, IV_C, IV_B, IV_A};
      end else begin
         if (ctl.reinit) begin
            chain_ff <= {IV_D, IV_C, IV_B, IV_A};
         end
         if (ctl.start) begin
            a_ff     <= chain_ff[0];
            b_ff     <= chain_ff[1];
            c_ff     <= chain_ff[2];
            d_ff     <= chain_ff[3];
            round_ff <= '0;
            run_ff   <= 1'b1;
         end else if (run_ff) begin
            a_ff     <= d_ff;
            b_ff     <= new_b;
            c_ff     <= b_ff;
            d_ff     <= c_ff;
            round_ff <= 6'(round_ff + 6'd1);
            if (round_ff == LAST_ROUND) begin
               run_ff <= 1'b0;
               fin_ff <= 1'b1;
            end
         end
         if (fin_ff) begin
            chain_ff[0] <= chain_ff[0] + a_ff;
            chain_ff[1] <= chain_ff[1] + b_ff;
            chain_ff[2] <= chain_ff[2] + c_ff;
            chain_ff[3] <= chain_ff[3] + d_ff;
            fin_ff      <= 1'b0;
         end
      end
   end

   assign chain = chain_ff;
   assign done  = fin_ff;

endmodule

[rtl/md5_digest_out.sv]
module md5_digest_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  md5_pkg::md5_words_type words,
   output logic                   busy,
   md5_rsp_if.source              rsp_ch
);
   import md5_pkg::*;

   md5_words_type word_ff;
   logic [1:0]    idx_ff;
   logic          pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         pend_ff <= 1'b1;
         idx_ff  <= '0;
         word_ff <= words;
      end else if (pend_ff && rsp_ch.ready) begin
         idx_ff <= 2'(idx_ff + 2'd1);
         if (idx_ff == 2'd3) begin
            pend_ff <= 1'b0;
         end
      end
   end

   assign busy               = pend_ff;
   assign rsp_ch.valid       = pend_ff;
   assign rsp_ch.digest_word = word_ff[idx_ff];
   assign rsp_ch.word_index  = idx_ff;
   assign rsp_ch.last        = (idx_ff == 2'd3);

endmodule

[rtl/md5_message_digest_top.sv]
// MD5 engine with one request and one response channel, both valid/ready.
// A request transaction with mode 0 absorbs data_byte into the message; one
// with mode 1 finishes the message and yields four response transactions,
// the digest words A to D with word_index 0 to 3 and last set on word D.
// The 64th byte of a block starts the compression, which runs one round per
// cycle from the block buffer memory and holds off requests until it ends.
// A finish writes the padding and the bit length one byte per cycle, with a
// compression in between if the padding spills into a second block, so it
// runs one or two compressions; it then hands the digest to the response
// register. The chaining words and byte count then return to their initial
// values and requests are taken again while the digest is still being
// delivered. If the receiver stalls, the words wait in the response register;
// a further finish is taken and compressed, but its digest is handed over
// only after they have all gone.
// Synchronous reset clears the sequencer, count and response valid and loads
// the initial chaining values; the block buffer needs no clearing.
module md5_message_digest_top (
   input  logic      clock,
   input  logic      reset,
   md5_req_if.sink   req_ch,
   md5_rsp_if.source rsp_ch
);
   import md5_pkg::*;

   md5_state_type   state_ff, state_in;
   logic [5:0]      pos_ff, pos_in;
   logic            first_ff, first_in;
   logic [63:0]     count_ff, count_in;

   md5_buf_wr_type  wr;
   md5_cmp_ctl_type ctl;
   logic [3:0]      rd_addr;
   logic [31:0]     rd_data;
   md5_words_type   chain;
   logic            cmp_done;
   logic            out_load;
   logic            out_busy;
   logic            accept;
   logic [63:0]     bit_len;

   md5_block_buf u_buf (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   md5_compress u_compress (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_data (rd_data),
      .rd_addr (rd_addr),
      .chain   (chain),
      .done    (cmp_done)
   );

   md5_digest_out u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (out_load),
      .words  (chain),
      .busy   (out_busy),
      .rsp_ch (rsp_ch)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   // The count does not move during a finish, so the length comes from it.
   assign bit_len      = {count_ff[60:0], 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         first_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         first_ff <= first_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      first_in   = first_ff;
      count_in   = count_ff;
      wr         = '0;
      ctl        = '0;
      out_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_ch.mode) begin
                  wr.en    = 1'b1;
                  wr.addr  = count_ff[5:0];
                  wr.data  = req_ch.data_byte;
                  count_in = count_ff + 64'd1;
                  if (count_ff[5:0] == LAST_POS) begin
                     ctl.start = 1'b1;
                     state_in  = ST_ABS_WAIT;
                  end
               end else begin
                  pos_in   = count_ff[5:0];
                  first_in = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_ABS_WAIT: begin
            if (cmp_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            // The marker byte goes first, then zeros up to the length field.
            wr.en    = 1'b1;
            wr.addr  = pos_ff;
            wr.data  = first_ff ? PAD_BYTE : ZERO_BYTE;
            first_in = 1'b0;
            if (pos_ff == LAST_POS) begin
               ctl.start = 1'b1;
               pos_in    = '0;
               state_in  = ST_PAD_WAIT;
            end else if (pos_ff == PAD_END_POS) begin
               pos_in   = LEN_POS;
               state_in = ST_LEN;
            end else begin
               pos_in = 6'(pos_ff + 6'd1);
            end
         end
         ST_PAD_WAIT: begin
            if (cmp_done) begin
               state_in = ST_PAD;
            end
         end
         ST_LEN: begin
            wr.en   = 1'b1;
            wr.addr = pos_ff;
            wr.data = bit_len[{pos_ff[2:0], 3'b000} +: 8];
            if (pos_ff == LAST_POS) begin
               ctl.start = 1'b1;
               pos_in    = '0;
               state_in  = ST_FIN_WAIT;
            end else begin
               pos_in = 6'(pos_ff + 6'd1);
            end
         end
         ST_FIN_WAIT: begin
            if (cmp_done) begin
               state_in = ST_FIN_LOAD;
            end
         end
         ST_FIN_LOAD: begin
            if (!out_busy) begin
               out_load   = 1'b1;
               ctl.reinit = 1'b1;
               count_in   = '0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[test/tb_md5_message_digest_top.sv]
`timescale 1ns / 100ps

module tb_md5_message_digest_top;

   localparam logic MODE_ABSORB = 1'b0;
   localparam logic MODE_FINISH = 1'b1;

   localparam int RESET_CYCLES     = 8;
   localparam int LONG_HOLD_CYCLES = 600;
   // The slowest correct run stays well under this limit, leaving plenty of room.
   localparam int CYCLE_LIMIT      = 400000;
   localparam int SETTLE_CYCLES    = 300;
   localparam int ITEM_TARGET      = 200;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_word_type;

   // Tracks the message being hashed and the digest words still owed by the
   // block. Each accepted request transaction is folded into a local MD5
   // state; a finish pads the message and queues the four chaining words.
   class md5_digest_tracker;
      logic [31:0]     hash_state [4];
      logic [7:0]      block_bytes [64];
      logic [63:0]     msg_len;
      int              fill;
      logic [31:0]     sine_k [64];
      int              shift_amt [16];
      digest_word_type awaited_words [$];
      int              errors;
      int              words_checked;
      int              requests_seen;
      int              digests_seen;

      function new();
         sine_k = '{
            32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
            32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
            32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
            32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
            32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
            32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
            32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
            32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
            32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
            32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
            32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
            32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
            32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
            32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
            32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
            32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
         };
         shift_amt = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
         errors = 0;
         words_checked = 0;
         requests_seen = 0;
         digests_seen = 0;
         restart();
      endfunction

      function void restart();
         hash_state = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476};
         msg_len = '0;
         fill = 0;
      endfunction

      function void run_rounds();
         logic [31:0] w [16];
         logic [31:0] a, b, c, d, f, sum, rotated, held;
         int g, grp, s;
         for (int j = 0; j < 16; j++) begin
            w[j] = {block_bytes[4*j+3], block_bytes[4*j+2],
                    block_bytes[4*j+1], block_bytes[4*j]};
         end
         a = hash_state[0];
         b = hash_state[1];
         c = hash_state[2];
         d = hash_state[3];
         for (int i = 0; i < 64; i++) begin
            grp = i / 16;
            case (grp)
               0: begin
                  f = d ^ (b & (c ^ d));
                  g = i;
               end
               1: begin
                  f = c ^ (d & (b ^ c));
                  g = (5 * i + 1) % 16;
               end
               2: begin
                  f = b ^ c ^ d;
                  g = (3 * i + 5) % 16;
               end
               default: begin
                  f = c ^ (b | ~d);
                  g = (7 * i) % 16;
               end
            endcase
            s = shift_amt[grp * 4 + i % 4];
            sum = a + f + w[g] + sine_k[i];
            rotated = (sum << s) | (sum >> (32 - s));
            held = d;
            d = c;
            c = b;
            b = b + rotated;
            a = held;
         end
         hash_state[0] += a;
         hash_state[1] += b;
         hash_state[2] += c;
         hash_state[3] += d;
      endfunction

      function void put_byte(logic [7:0] value);
         block_bytes[fill] = value;
         fill++;
         if (fill == 64) begin
            run_rounds();
            fill = 0;
         end
      endfunction

      function void take_request(logic mode, logic [7:0] data_byte);
         logic [63:0] bit_len;
         digest_word_type dw;
         requests_seen++;
         if (mode == MODE_ABSORB) begin
            put_byte(data_byte);
            msg_len++;
         end else begin
            bit_len = msg_len << 3;
            put_byte(8'h80);
            while (fill != 56) put_byte(8'h00);
            for (int i = 0; i < 8; i++) put_byte(bit_len[8*i +: 8]);
            for (int i = 0; i < 4; i++) begin
               dw.word = hash_state[i];
               dw.index = 2'(i);
               dw.last = (i == 3);
               awaited_words.push_back(dw);
            end
            digests_seen++;
            restart();
         end
      endfunction

      function void compare_word(logic [31:0] word, logic [1:0] index, logic last);
         digest_word_type want;
         words_checked++;
         if (awaited_words.size() == 0) begin
            errors++;
            $display("%0t: digest word %h index %0d last %0b arrived with none expected",
                     $time, word, index, last);
            return;
         end
         want = awaited_words.pop_front();
         if (word !== want.word) begin
            errors++;
            $display("%0t: digest_word expected %h actual %h", $time, want.word, word);
         end
         if (index !== want.index) begin
            errors++;
            $display("%0t: word_index expected %0d actual %0d", $time, want.index, index);
         end
         if (last !== want.last) begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, last);
         end
      endfunction

      function int pending();
         return awaited_words.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   md5_req_if req_ch ();
   md5_rsp_if rsp_ch ();

   md5_message_digest_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   md5_digest_tracker tracker;

   // Random idling on both channels is allowed while this is set.
   bit idle_en = 1'b0;
   // The stimulus bumps this to ask the receiver for one long hold-off.
   int hold_requests = 0;
   int items_sent = 0;
   int messages_sent = 0;
   int longest_msg = 0;
   int cycle_count = 0;

   always #5 clock = ~clock;

   // Watchdog. A correct run never gets close to this limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles with %0d digest words outstanding",
                  $time, CYCLE_LIMIT, tracker.pending());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Monitor. Both channels are sampled at the rising edge, before any of
   // the nonblocking updates of that edge have landed, so every transaction
   // is seen with the values that the block itself saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            tracker.take_request(req_ch.mode, req_ch.data_byte);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            tracker.compare_word(rsp_ch.digest_word, rsp_ch.word_index, rsp_ch.last);
         end
      end
   end

   // Receiver. Ready is either held low for a random burst of cycles, held
   // low for one long stretch on request, or left high. At most one update
   // of ready happens per clock edge.
   initial begin : receiver
      int stall_left;
      int holds_served;
      stall_left = 0;
      holds_served = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            rsp_ch.ready <= 1'b0;
            for (int n = 0; n < LONG_HOLD_CYCLES; n++) @(posedge clock);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
            @(posedge clock);
         end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_ch.ready <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offers one request transaction and returns at the edge that accepts it.
   // Valid stays high on return; the next call either replaces the payload
   // or drops valid for a gap, so valid gets one update per edge.
   task automatic send_item(input logic mode, input logic [7:0] data_byte);
      int gap;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.data_byte <= data_byte;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_item(MODE_ABSORB, 8'($urandom_range(0, 255)));
      end
      // The byte field of a finish is ignored, but it still gets random bits.
      send_item(MODE_FINISH, 8'($urandom_range(0, 255)));
      messages_sent++;
      if (len > longest_msg) longest_msg = len;
   endtask

   // Stops offering and waits until every digest word owed has come out.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int boundary_len [6];
      int len;
      int pick;
      boundary_len = '{55, 56, 63, 64, 119, 120};
      tracker = new();
      req_ch.valid <= 1'b0;
      req_ch.mode <= MODE_ABSORB;
      req_ch.data_byte <= 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with idling on. The empty message comes first, right
      // after reset, then "abc", then single bytes at both ends of the byte
      // range, and a second empty message right after a digest to show that
      // the chaining words went back to their initial values.
      idle_en = 1'b1;
      send_message(0);
      send_item(MODE_ABSORB, 8'h61);
      send_item(MODE_ABSORB, 8'h62);
      send_item(MODE_ABSORB, 8'h63);
      send_item(MODE_FINISH, 8'hFF);
      messages_sent++;
      send_item(MODE_ABSORB, 8'h00);
      send_item(MODE_FINISH, 8'h00);
      send_item(MODE_ABSORB, 8'hFF);
      send_item(MODE_FINISH, 8'hFF);
      send_item(MODE_FINISH, 8'h00);
      messages_sent += 3;

      // The sender pauses here until every digest word has been delivered.
      wait_drained();

      // Back-pressure. The receiver holds off for a long stretch while new
      // messages keep coming; the first digest sits in the response register
      // and the next finish cannot hand over its digest, so the request channel stalls.
      hold_requests++;
      send_message(4);
      send_message(9);
      send_message(1);
      wait_drained();

      // Random messages. Most are short, some are mid-sized, and about one in
      // four has a length right at a block boundary: 55 leaves just room for
      // the length, 56 forces an extra padding block, 64 makes the last byte
      // start a compression, and 119 and 120 do the same one block later.
      // The last message is cut short so the run ends near the item target.
      // The 64-bit count cannot wrap in any run of sane length, so the
      // overflow case is out of reach here. Idling stops for the last part.
      while (items_sent < ITEM_TARGET) begin
         idle_en = (items_sent < 180);
         pick = $urandom_range(0, 19);
         if (pick < 11) begin
            len = $urandom_range(0, 12);
         end else if (pick < 15) begin
            len = $urandom_range(13, 50);
         end else begin
            len = boundary_len[$urandom_range(0, 5)];
         end
         if (len > ITEM_TARGET - 1 - items_sent) len = ITEM_TARGET - 1 - items_sent;
         send_message(len);
      end
      idle_en = 1'b0;

      wait_drained();
      // Give a stray extra word time to show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (tracker.pending() != 0) begin
         $display("%0t: %0d digest words never arrived", $time, tracker.pending());
      end
      $display("Hashed %0d messages over %0d request transactions, longest %0d bytes,",
               messages_sent, tracker.requests_seen, longest_msg);
      $display("and compared %0d digest words, with one long receiver hold-off.",
               tracker.words_checked);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
